// ===== rtl/rvat_pkg.sv =====
// Shared types and constants of the range view access translator.
`timescale 1ns / 1ps
package rvat_pkg;
  localparam int unsigned MAX_VIEWS = 8;
  localparam int unsigned AddrW  = 64;
  localparam int unsigned RightsW = 3;
  localparam int unsigned PolW   = 8;
  localparam int unsigned WidxW  = 32;
  localparam int unsigned GenW   = 32;
  localparam int unsigned ReqW   = 32;
  localparam int unsigned CountW = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW = 432;
  localparam int unsigned OutDataW = 336;

  localparam logic [CfgIdxW-1:0] CFG_VIEW_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GEN        = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_POLICY     = 2'd3;

  localparam logic ACT_LOAD = 1'b0;

  typedef struct packed {
    logic [AddrW-1:0]   start;
    logic [AddrW-1:0]   stop;
    logic [AddrW-1:0]   host;
    logic [RightsW-1:0] perm;
    logic [PolW-1:0]    pol;
    logic [WidxW-1:0]   widx;
    logic [GenW-1:0]    gen;
  } view_t;
endpackage

// ===== rtl/range_view_access_translator.sv =====
// Top level of the range view access translator.
// Usage: words enter on in_* (in_tuser = action: 0 load entry, 1 resolve).
// A load writes one table entry and answers ok with all fields zero.
// A resolve first checks the request, then sweeps the table entries below
// view_count (ST_CHK_A then ST_CHK_B for each), then walks the covering
// entries; each walk step scans the table from entry 0 in ST_FIND and then
// applies the hit in ST_HIT. The table has one read port. One result word
// per input word on out_*. in_tready is high only while the sequencer is
// idle. The finished result sits in an output register; the next word is
// taken while it waits, and a further result waits until out_tready drains
// the register. Reset (rst_n low, synchronous) clears the sequencer, the
// output valid and the registers (view_count 1, others 0) and the last
// window. Table entries are undefined until loaded. The user must make
// cfg_* writes only while idle; the block does not enforce it.
`timescale 1ns / 1ps
module range_view_access_translator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // view_slot, range_first, range_end, host_base, view_rights, view_policy,
  // view_write_slot, view_generation, access_address, access_size,
  // required_rights
  input  logic [rvat_pkg::InDataW-1:0]    in_tdata,
  // action
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // fault_addr, fault_rights, window_first, window_last, window_delta,
  // window_rights, window_policy, window_write_slot
  output logic [rvat_pkg::OutDataW-1:0]   out_tdata,
  // ok, window_changed
  output logic [1:0]                      out_tuser,
  input  logic                            cfg_we,
  input  logic [rvat_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [rvat_pkg::CfgDataW-1:0]   cfg_wdata
);
  import rvat_pkg::*;

  localparam int unsigned IW = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;
  localparam int unsigned NW = CountW + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE, ST_CHK_A, ST_CHK_B, ST_TOP, ST_FIND, ST_HIT, ST_XFER
  } state_t;

  state_t state_r;

  logic [CountW-1:0]  view_count_r;
  logic [2:0]         active_r;
  logic [GenW-1:0]    gen_r;
  logic [PolW-1:0]    policy_r;

  logic [AddrW-1:0]   addr_r, size_r, last_r, cursor_r, prev_r, len_r;
  logic [AddrW-1:0]   first_r, delta_r, cur_first_r, cur_last_r;
  logic [ReqW-1:0]    req_r;
  logic [RightsW-1:0] perm_r;
  logic [CountW-1:0]  i_r, i_nxt;
  logic [NW-1:0]      n_r;

  logic               res_ok_r, res_chg_r;
  logic [AddrW-1:0]   res_fa_r, res_wf_r, res_wl_r, res_wd_r;
  logic [ReqW-1:0]    res_fr_r;
  logic [RightsW-1:0] res_wr_r;
  logic [PolW-1:0]    res_wp_r;
  logic [WidxW-1:0]   res_ws_r;

  logic               out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic [1:0]         out_user_r;

  view_t              wentry, rentry;
  logic               tbl_we;
  logic [2:0]         in_slot;
  logic [AddrW:0]     pre_sum;
  logic [AddrW:0]     host_sum;
  logic [AddrW-1:0]   hit_d;
  logic               in_acc;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_slot   = in_tdata[2:0];

  assign wentry.start = in_tdata[66:3];
  assign wentry.stop  = in_tdata[130:67];
  assign wentry.host  = in_tdata[194:131];
  assign wentry.perm  = in_tdata[197:195];
  assign wentry.pol   = in_tdata[205:198];
  assign wentry.widx  = in_tdata[237:206];
  assign wentry.gen   = in_tdata[269:238];
  assign tbl_we = in_acc && (in_tuser == ACT_LOAD) && ({1'b0, in_slot} < (MAX_VIEWS));

  // read data follows i_r: the address is the next index
  rvat_view_table #(.WIDTH($bits(view_t)), .DEPTH(MAX_VIEWS), .AW(IW)) u_table (
    .clk    (clk),
    .we     (tbl_we),
    .waddr  (IW'(in_slot)),
    .wdata  (wentry),
    .raddr  (i_nxt[IW-1:0]),
    .rdata  (rentry)
  );

  assign pre_sum  = {1'b0, addr_r} + {1'b0, size_r};
  assign host_sum = {1'b0, rentry.host} + {1'b0, len_r};
  assign hit_d    = rentry.host - rentry.start;

  always_comb begin
    i_nxt = i_r;
    case (state_r)
      ST_PRE, ST_TOP: i_nxt = '0;
      ST_CHK_B: begin
        if (!host_sum[AddrW] && !(i_r + CountW'(1) >= view_count_r)) begin
          i_nxt = i_r + CountW'(1);
        end
      end
      ST_FIND: begin
        if (!(i_r >= view_count_r || rentry.start > cursor_r) && !(cursor_r < rentry.stop)) begin
          i_nxt = i_r + CountW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_count_r <= CountW'(1);
      active_r     <= '0;
      gen_r        <= '0;
      policy_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VIEW_COUNT: view_count_r <= cfg_wdata[CountW-1:0];
        CFG_ACTIVE:     active_r     <= cfg_wdata[2:0];
        CFG_GEN:        gen_r        <= cfg_wdata[GenW-1:0];
        CFG_POLICY:     policy_r     <= cfg_wdata[PolW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cur_first_r <= '0;
      cur_last_r  <= '0;
    end else begin
      i_r <= i_nxt;
      if (out_valid_r && out_tready && state_r != ST_XFER) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            res_ok_r  <= 1'b0;
            res_chg_r <= 1'b0;
            res_fa_r  <= '0;
            res_fr_r  <= '0;
            res_wf_r  <= '0;
            res_wl_r  <= '0;
            res_wd_r  <= '0;
            res_wr_r  <= '0;
            res_wp_r  <= '0;
            res_ws_r  <= '0;
            addr_r    <= in_tdata[333:270];
            size_r    <= in_tdata[397:334];
            req_r     <= in_tdata[429:398];
            cursor_r  <= in_tdata[333:270];
            if (in_tuser == ACT_LOAD) begin
              res_ok_r <= 1'b1;
              state_r  <= ST_XFER;
            end else begin
              state_r <= ST_PRE;
            end
          end
        end
        ST_PRE: begin
          n_r    <= '0;
          prev_r <= '0;
          last_r <= pre_sum[AddrW-1:0];
          if (view_count_r == '0 || {1'b0, active_r} >= view_count_r ||
              view_count_r > CountW'(MAX_VIEWS) || size_r == '0 || pre_sum[AddrW] ||
              req_r == '0 || req_r[ReqW-1:RightsW] != '0) begin
            res_fa_r <= cursor_r;
            res_fr_r <= req_r;
            state_r  <= ST_XFER;
          end else begin
            state_r <= ST_CHK_A;
          end
        end
        ST_CHK_A: begin
          len_r <= rentry.stop - rentry.start;
          if (rentry.stop <= rentry.start || rentry.pol != policy_r ||
              rentry.gen != gen_r || rentry.perm == '0 ||
              (i_r != '0 && rentry.start < prev_r)) begin
            res_fa_r <= cursor_r;
            res_fr_r <= req_r;
            state_r  <= ST_XFER;
          end else begin
            state_r <= ST_CHK_B;
          end
        end
        ST_CHK_B: begin
          prev_r <= rentry.stop;
          if (host_sum[AddrW]) begin
            res_fa_r <= cursor_r;
            res_fr_r <= req_r;
            state_r  <= ST_XFER;
          end else if (i_r + CountW'(1) >= view_count_r) begin
            state_r <= ST_TOP;
          end else begin
            state_r <= ST_CHK_A;
          end
        end
        ST_TOP: begin
          if (n_r <= {1'b0, view_count_r} && cursor_r < last_r) begin
            state_r <= ST_FIND;
          end else if (cursor_r < last_r) begin
            res_fa_r <= cursor_r;
            res_fr_r <= req_r;
            state_r  <= ST_XFER;
          end else begin
            res_ok_r    <= 1'b1;
            res_chg_r   <= (cur_first_r != first_r) || (cur_last_r != cursor_r);
            cur_first_r <= first_r;
            cur_last_r  <= cursor_r;
            res_wf_r    <= first_r;
            res_wl_r    <= cursor_r;
            res_wd_r    <= delta_r;
            res_wr_r    <= perm_r;
            state_r     <= ST_XFER;
          end
        end
        ST_FIND: begin
          if (i_r >= view_count_r || rentry.start > cursor_r) begin
            res_fa_r <= cursor_r;
            res_fr_r <= req_r;
            state_r  <= ST_XFER;
          end else if (cursor_r < rentry.stop) begin
            state_r <= ST_HIT;
          end
        end
        ST_HIT: begin
          if ((rentry.perm & req_r[RightsW-1:0]) != req_r[RightsW-1:0] ||
              (n_r != '0 && hit_d != delta_r)) begin
            res_fa_r <= cursor_r;
            res_fr_r <= req_r;
            state_r  <= ST_XFER;
          end else begin
            if (n_r == '0) begin
              first_r <= rentry.start;
              perm_r  <= rentry.perm;
              delta_r <= hit_d;
            end
            res_wp_r <= rentry.pol;
            res_ws_r <= rentry.widx;
            cursor_r <= (rentry.stop < last_r) ? rentry.stop : last_r;
            n_r      <= n_r + NW'(1);
            state_r  <= ST_TOP;
          end
        end
        ST_XFER: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= {res_chg_r, res_ok_r};
            out_data_r  <= {5'd0, (res_ok_r ? res_ws_r : WidxW'(0)),
                            (res_ok_r ? res_wp_r : PolW'(0)), res_wr_r, res_wd_r, res_wl_r,
                            res_wf_r, res_fr_r, res_fa_r};
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_load_to_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == ACT_LOAD) |=> (state_r == ST_XFER))
    else $error("load did not go straight to result");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HIT) |-> (n_r <= {1'b0, view_count_r}))
    else $error("walk exceeded view count");
  a_ok_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r[0]) |-> (out_data_r[95:0] == '0))
    else $error("success word carries fault fields");
endmodule

// ===== rtl/rvat_view_table.sv =====
// Generic RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module rvat_view_table #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
